// ===== rtl/octpart_pkg.sv =====
package octpart_pkg;

    // Fixed field widths
    localparam int COORD_W  = 32;
    localparam int SLOT_W   = 17;
    localparam int CNT_W    = 6;
    localparam int LIMIT_W  = 6;
    localparam int BASE_W   = 16;
    localparam int RADIUS_W = 31;
    localparam int OCT_W    = 3;
    localparam int NUM_OCT  = 8;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX = 3'd5;

    // Result kinds
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_DESC  = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_PSCAN,
        ST_READ,
        ST_EMIT,
        ST_DSCAN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic load;
        logic leaf_start;
        logic split_start;
        logic grp_start;
        logic oct_inc;
        logic desc_init;
        logic rd;
        logic emit_pt;
        logic emit_desc;
        logic clear;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic leaf_node;
        logic leaf_run;
        logic oct_end;
        logic cnt_nz;
        logic rem_one;
        logic out_free;
        logic desc_last;
    } t_status;

endpackage

// ===== rtl/octpart_if.sv =====
// Point input channel
interface octpart_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] weight;
    logic               last;

    modport source (output valid, x, y, z, weight, last, input ready);
    modport sink   (input valid, x, y, z, weight, last, output ready);
endinterface

// Result output channel
interface octpart_result_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [2:0]         octant;
    logic [16:0]        slot;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] pweight;
    logic [5:0]         child_count;
    logic               overflow;
    logic               final_res;

    modport source (output valid, kind, octant, slot, px, py, pz, pweight,
                    child_count, overflow, final_res, input ready);
    modport sink   (input valid, kind, octant, slot, px, py, pz, pweight,
                    child_count, overflow, final_res, output ready);
endinterface

// Configuration write channel
interface octpart_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/octpart_ctrl.sv =====
module octpart_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  octpart_pkg::t_status i_st,
    output octpart_pkg::t_cmd    o_cmd
);

    octpart_pkg::t_state r_state;
    octpart_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= octpart_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            octpart_pkg::ST_LOAD: begin
                if (i_st.in_valid && i_st.in_last) begin
                    n_state = octpart_pkg::ST_SETUP;
                end
            end
            octpart_pkg::ST_SETUP: begin
                n_state = i_st.leaf_node ? octpart_pkg::ST_READ : octpart_pkg::ST_PSCAN;
            end
            octpart_pkg::ST_PSCAN: begin
                if (i_st.oct_end) begin
                    n_state = octpart_pkg::ST_DSCAN;
                end else if (i_st.cnt_nz) begin
                    n_state = octpart_pkg::ST_READ;
                end
            end
            octpart_pkg::ST_READ: begin
                n_state = octpart_pkg::ST_EMIT;
            end
            octpart_pkg::ST_EMIT: begin
                if (i_st.out_free) begin
                    if (!i_st.rem_one) begin
                        n_state = octpart_pkg::ST_READ;
                    end else if (i_st.leaf_run) begin
                        n_state = octpart_pkg::ST_LOAD;
                    end else begin
                        n_state = octpart_pkg::ST_PSCAN;
                    end
                end
            end
            octpart_pkg::ST_DSCAN: begin
                if (i_st.cnt_nz && i_st.out_free && i_st.desc_last) begin
                    n_state = octpart_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = octpart_pkg::ST_LOAD;
            end
        endcase
    end

    // Command decode
    always_comb begin
        o_cmd = '0;
        case (r_state)
            octpart_pkg::ST_LOAD: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_st.in_valid;
            end
            octpart_pkg::ST_SETUP: begin
                o_cmd.leaf_start  = i_st.leaf_node;
                o_cmd.split_start = !i_st.leaf_node;
            end
            octpart_pkg::ST_PSCAN: begin
                if (i_st.oct_end) begin
                    o_cmd.desc_init = 1'b1;
                end else if (i_st.cnt_nz) begin
                    o_cmd.grp_start = 1'b1;
                end else begin
                    o_cmd.oct_inc = 1'b1;
                end
            end
            octpart_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            octpart_pkg::ST_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit_pt = 1'b1;
                    if (i_st.rem_one) begin
                        o_cmd.clear   = i_st.leaf_run;
                        o_cmd.oct_inc = !i_st.leaf_run;
                    end
                end
            end
            octpart_pkg::ST_DSCAN: begin
                if (!i_st.cnt_nz) begin
                    o_cmd.oct_inc = 1'b1;
                end else if (i_st.out_free) begin
                    o_cmd.emit_desc = 1'b1;
                    o_cmd.oct_inc   = 1'b1;
                    o_cmd.clear     = i_st.desc_last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/octpart_dp.sv =====
module octpart_dp #(
    parameter int MAX_POINTS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  octpart_pkg::t_cmd    i_cmd,
    output octpart_pkg::t_status o_st,
    octpart_cfg_if.sink          i_cfg,
    octpart_point_if.sink        i_pt,
    octpart_result_if.source     o_res
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int HW = $clog2(MAX_POINTS + 1);
    localparam logic [HW-1:0] FULL = HW'(MAX_POINTS);
    localparam int PW = 4 * octpart_pkg::COORD_W;

    // Saturating child centre: c +/- h clipped to signed 32 bits
    function automatic logic [31:0] f_child(input logic [31:0] c,
                                            input logic [30:0] h,
                                            input logic up);
        logic [32:0] s;
        s = up ? ({c[31], c} + {2'b00, h}) : ({c[31], c} - {2'b00, h});
        if (s[32] != s[31]) begin
            f_child = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            f_child = s[31:0];
        end
    endfunction

    // Configuration registers
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic signed [31:0] r_center_z;
    logic [octpart_pkg::RADIUS_W-1:0] r_radius;
    logic [octpart_pkg::LIMIT_W-1:0]  r_leaf_limit;
    logic [octpart_pkg::BASE_W-1:0]   r_base;

    // Node state
    logic [HW-1:0] r_held;
    logic          r_dropped;
    logic [HW-1:0] r_cnt  [octpart_pkg::NUM_OCT];
    logic [AW-1:0] r_head [octpart_pkg::NUM_OCT];
    logic [AW-1:0] r_tail [octpart_pkg::NUM_OCT];

    // Point store and per-octant link memory
    logic [PW-1:0] r_store [MAX_POINTS];
    logic [AW-1:0] r_next  [MAX_POINTS];
    logic [PW-1:0] r_rd_data;
    logic [AW-1:0] r_nx_data;

    // Drain sequencing
    logic [3:0]    r_oct;
    logic          r_leaf;
    logic [AW-1:0] r_rd_ptr;
    logic [HW-1:0] r_rem;
    logic [HW-1:0] r_pos;

    // Output register
    logic        r_out_valid;
    logic        r_kind;
    logic [2:0]  r_octant;
    logic [16:0] r_slot;
    logic [31:0] r_px;
    logic [31:0] r_py;
    logic [31:0] r_pz;
    logic [31:0] r_pw;
    logic [5:0]  r_ccount;
    logic        r_ovf;
    logic        r_final;

    logic [2:0]    w_in_oct;
    logic [2:0]    w_cnt_addr;
    logic [HW-1:0] w_cnt;
    logic          w_room;
    logic [AW-1:0] w_held_idx;
    logic [7:0]    w_nz;
    logic          w_desc_last;
    logic          w_rem_one;
    logic          w_out_free;
    logic [30:0]   w_half;
    logic [16:0]   w_slot;

    // Octant code of the incoming point
    assign w_in_oct = {i_pt.z > r_center_z, i_pt.y > r_center_y, i_pt.x > r_center_x};

    assign w_cnt_addr  = i_cmd.load ? w_in_oct : r_oct[2:0];
    assign w_cnt       = r_cnt[w_cnt_addr];
    assign w_room      = (r_held != FULL);
    assign w_held_idx  = r_held[AW-1:0];
    assign w_rem_one   = (r_rem == HW'(1));
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_half      = {1'b0, r_radius[30:1]};
    assign w_slot      = 17'(r_base) + 17'(r_pos);

    // Non-empty octants and whether any lies above the current one
    always_comb begin
        for (int i = 0; i < octpart_pkg::NUM_OCT; i++) begin
            w_nz[i] = (r_cnt[i] != '0);
        end
    end
    assign w_desc_last = ((w_nz >> ({1'b0, r_oct[2:0]} + 4'd1)) == 8'd0);

    // Configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_center_z   <= '0;
            r_radius     <= 31'd65536;
            r_leaf_limit <= 6'd8;
            r_base       <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                octpart_pkg::CFG_CENTER_X:   r_center_x   <= i_cfg.data;
                octpart_pkg::CFG_CENTER_Y:   r_center_y   <= i_cfg.data;
                octpart_pkg::CFG_CENTER_Z:   r_center_z   <= i_cfg.data;
                octpart_pkg::CFG_RADIUS:     r_radius     <= i_cfg.data[30:0];
                octpart_pkg::CFG_LEAF_LIMIT: r_leaf_limit <= i_cfg.data[5:0];
                octpart_pkg::CFG_BASE_INDEX: r_base       <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Fill count, drop flag and octant counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_held    <= '0;
            r_dropped <= 1'b0;
            for (int i = 0; i < octpart_pkg::NUM_OCT; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.load) begin
            if (w_room) begin
                r_held          <= r_held + HW'(1);
                r_cnt[w_in_oct] <= w_cnt + HW'(1);
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    // Per-octant list heads and tails
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            if (w_cnt == '0) begin
                r_head[w_in_oct] <= w_held_idx;
            end
            r_tail[w_in_oct] <= w_held_idx;
        end
    end

    // Store and link memories, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_store[w_held_idx] <= {i_pt.weight, i_pt.z, i_pt.y, i_pt.x};
            if (w_cnt != '0) begin
                r_next[r_tail[w_in_oct]] <= w_held_idx;
            end
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_store[r_rd_ptr];
            r_nx_data <= r_next[r_rd_ptr];
        end
    end

    // Drain control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct  <= '0;
            r_leaf <= 1'b0;
        end else begin
            if (i_cmd.leaf_start) begin
                r_leaf <= 1'b1;
            end else if (i_cmd.split_start) begin
                r_leaf <= 1'b0;
            end
            if (i_cmd.split_start || i_cmd.desc_init) begin
                r_oct <= '0;
            end else if (i_cmd.oct_inc) begin
                r_oct <= r_oct + 4'd1;
            end
        end
    end

    // Read pointer, remaining and position
    always_ff @(posedge i_clk) begin
        if (i_cmd.leaf_start) begin
            r_rd_ptr <= '0;
            r_rem    <= r_held;
        end else if (i_cmd.grp_start) begin
            r_rd_ptr <= r_head[r_oct[2:0]];
            r_rem    <= w_cnt;
        end else if (i_cmd.emit_pt) begin
            r_rd_ptr <= r_leaf ? (r_rd_ptr + AW'(1)) : r_nx_data;
            r_rem    <= r_rem - HW'(1);
        end
        if (i_cmd.leaf_start || i_cmd.split_start || i_cmd.desc_init) begin
            r_pos <= '0;
        end else if (i_cmd.emit_pt) begin
            r_pos <= r_pos + HW'(1);
        end else if (i_cmd.emit_desc) begin
            r_pos <= r_pos + w_cnt;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_pt || i_cmd.emit_desc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pt) begin
            r_kind   <= octpart_pkg::KIND_POINT;
            r_octant <= r_leaf ? 3'd0 : r_oct[2:0];
            r_slot   <= w_slot;
            r_px     <= r_rd_data[31:0];
            r_py     <= r_rd_data[63:32];
            r_pz     <= r_rd_data[95:64];
            r_pw     <= r_rd_data[127:96];
            r_ccount <= '0;
            r_ovf    <= r_dropped;
            r_final  <= r_leaf && w_rem_one;
        end else if (i_cmd.emit_desc) begin
            r_kind   <= octpart_pkg::KIND_DESC;
            r_octant <= r_oct[2:0];
            r_slot   <= w_slot;
            r_px     <= f_child(r_center_x, w_half, r_oct[0]);
            r_py     <= f_child(r_center_y, w_half, r_oct[1]);
            r_pz     <= f_child(r_center_z, w_half, r_oct[2]);
            r_pw     <= '0;
            r_ccount <= 6'(w_cnt);
            r_ovf    <= r_dropped;
            r_final  <= w_desc_last;
        end
    end

    assign i_pt.ready        = i_cmd.in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.octant      = r_octant;
    assign o_res.slot        = r_slot;
    assign o_res.px          = r_px;
    assign o_res.py          = r_py;
    assign o_res.pz          = r_pz;
    assign o_res.pweight     = r_pw;
    assign o_res.child_count = r_ccount;
    assign o_res.overflow    = r_ovf;
    assign o_res.final_res   = r_final;

    // Status back to the controller
    assign o_st.in_valid  = i_pt.valid;
    assign o_st.in_last   = i_pt.last;
    assign o_st.leaf_node = (7'(r_held) <= 7'(r_leaf_limit));
    assign o_st.leaf_run  = r_leaf;
    assign o_st.oct_end   = r_oct[3];
    assign o_st.cnt_nz    = (w_cnt != '0);
    assign o_st.rem_one   = w_rem_one;
    assign o_st.out_free  = w_out_free;
    assign o_st.desc_last = w_desc_last;

endmodule

// ===== rtl/octant_partition_core.sv =====
// Octree node partitioner. Points of one node are taken one per cycle until a
// point marked last; points past MAX_POINTS are dropped and flag overflow on
// every result of that node. The node is then drained through a single output
// register: a leaf (count at most leaf_limit) returns its points in arrival
// order, otherwise the points come out grouped by octant code 0..7 in arrival
// order within each octant, followed by one descriptor per non-empty octant.
// Sequence for a node: its points are loaded, a setup state follows, then for
// each point result a registered read of the point store is followed by the
// output register load; a split node first scans the octants in turn for
// points and closes the scan, then scans the octants for descriptors, up to
// the highest occupied octant. Within an octant the points are found by
// walking a per-octant link list in a small memory, so the read port sets the
// point rate: each point is read before its result is loaded. Output stalls
// hold the drain. No new point is taken from the last point until the run's
// final result is in the output register. Configuration writes are always
// ready.
module octant_partition_core #(
    parameter int MAX_POINTS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    octpart_cfg_if.sink       i_cfg,
    octpart_point_if.sink     i_pt,
    octpart_result_if.source  o_res
);

    octpart_pkg::t_cmd    w_cmd;
    octpart_pkg::t_status w_st;

    // Sequencer
    octpart_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    // Stores, counts and output register
    octpart_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_st    (w_st),
        .i_cfg   (i_cfg),
        .i_pt    (i_pt),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // Last point closes the input until the run is drained
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready && i_pt.last) |=> !i_pt.ready)
        else $error("input still open after last point");

    // Descriptors only for non-empty octants
    a_desc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind) |-> (o_res.child_count != 6'd0))
        else $error("descriptor with zero count");

    // A run ends on a point only for a leaf
    a_leaf_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.final_res && !o_res.kind) |-> (o_res.octant == 3'd0))
        else $error("split node ended on a point result");

    // Point results carry no child count
    a_pt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.kind) |-> (o_res.child_count == 6'd0))
        else $error("point result with child count");
`endif

endmodule

// ===== tb/tb_octant_partition_core.sv =====
`timescale 1ns / 1ps

module tb_octant_partition_core;

    localparam int MAX_PTS    = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 4;
    localparam int TARGET_PTS = 210;
    localparam int SPAN       = 2 ** 18;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // Indexes outside the register map; writes to them must change nothing
    localparam logic [octpart_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [octpart_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic               last;
    } t_point;

    typedef struct {
        logic               kind;
        logic [2:0]         octant;
        logic [16:0]        slot;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] pw;
        logic [5:0]         count;
        logic               ovf;
        logic               fin;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    octpart_point_if  pt_if ();
    octpart_result_if res_if ();
    octpart_cfg_if    cfg_if ();

    octant_partition_core #(.MAX_POINTS(MAX_PTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pt    (pt_if),
        .o_res   (res_if)
    );

    // Clock, 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Node register copy, reset values
    logic signed [31:0] ctr_x    = '0;
    logic signed [31:0] ctr_y    = '0;
    logic signed [31:0] ctr_z    = '0;
    logic [30:0]        rad      = 31'd65536;
    logic [5:0]         leaf_lim = 6'd8;
    logic [15:0]        base     = '0;

    // Points of the node being loaded
    t_point     held_pts [MAX_PTS];
    logic [2:0] held_oct [MAX_PTS];
    int         oct_count [octpart_pkg::NUM_OCT] = '{default: 0};
    int         n_held      = 0;
    logic       lost_points = 1'b0;

    t_point  points_to_send [$];
    t_result node_results [$];

    int   send_gap    = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    logic steady      = 1'b0;

    int mismatches    = 0;
    int results_seen  = 0;
    int points_taken  = 0;
    int stim_count    = 0;
    int leaf_nodes    = 0;
    int split_nodes   = 0;
    int dropped_nodes = 0;
    int reg_writes    = 0;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("result %0d: %s got %h, want %h", results_seen, name, got, want));
    endtask

    task automatic apply_reg(input logic [octpart_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        case (idx)
            octpart_pkg::CFG_CENTER_X:   ctr_x = data;
            octpart_pkg::CFG_CENTER_Y:   ctr_y = data;
            octpart_pkg::CFG_CENTER_Z:   ctr_z = data;
            octpart_pkg::CFG_RADIUS:     rad = data[30:0];
            octpart_pkg::CFG_LEAF_LIMIT: leaf_lim = data[5:0];
            octpart_pkg::CFG_BASE_INDEX: base = data[15:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic t_result point_result(input t_point p, input logic [2:0] oc,
                                             input int pos);
        t_result r;
        r.kind   = octpart_pkg::KIND_POINT;
        r.octant = oc;
        r.slot   = 17'(base) + 17'(pos);
        r.px     = p.x;
        r.py     = p.y;
        r.pz     = p.z;
        r.pw     = p.w;
        r.count  = '0;
        r.ovf    = lost_points;
        r.fin    = 1'b0;
        return r;
    endfunction

    // Centre moved by half the radius, clamped to the signed 32-bit range
    function automatic logic signed [31:0] child_centre(input logic signed [31:0] c,
                                                        input logic up, input longint half);
        longint s;
        s = longint'(c) + (up ? half : -half);
        if (s > S32_MAX) return 32'sh7FFF_FFFF;
        if (s < S32_MIN) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    // Load one point; on the last point work out the whole output run
    task automatic absorb_point(input t_point p);
        logic [2:0] oc;
        int         pos;
        longint     half;
        t_result    r;
        t_result    run [$];
        if (n_held < MAX_PTS) begin
            oc = {p.z > ctr_z, p.y > ctr_y, p.x > ctr_x};
            held_pts[n_held] = p;
            held_oct[n_held] = oc;
            oct_count[oc]++;
            n_held++;
        end else begin
            lost_points = 1'b1;
        end
        if (!p.last) return;

        if (n_held <= int'(leaf_lim)) begin
            for (int i = 0; i < n_held; i++)
                run.push_back(point_result(held_pts[i], 3'd0, i));
            leaf_nodes++;
        end else begin
            pos = 0;
            for (int o = 0; o < octpart_pkg::NUM_OCT; o++)
                for (int i = 0; i < n_held; i++)
                    if (held_oct[i] == 3'(o)) begin
                        run.push_back(point_result(held_pts[i], 3'(o), pos));
                        pos++;
                    end
            // one descriptor per occupied octant
            half = longint'(rad >> 1);
            pos = 0;
            for (int o = 0; o < octpart_pkg::NUM_OCT; o++) begin
                if (oct_count[o] == 0) continue;
                r.kind   = octpart_pkg::KIND_DESC;
                r.octant = 3'(o);
                r.slot   = 17'(base) + 17'(pos);
                r.px     = child_centre(ctr_x, o[0], half);
                r.py     = child_centre(ctr_y, o[1], half);
                r.pz     = child_centre(ctr_z, o[2], half);
                r.pw     = '0;
                r.count  = 6'(oct_count[o]);
                r.ovf    = lost_points;
                r.fin    = 1'b0;
                run.push_back(r);
                pos += oct_count[o];
            end
            split_nodes++;
        end

        for (int i = 0; i < run.size(); i++) begin
            r = run[i];
            r.fin = (i == run.size() - 1);
            node_results.push_back(r);
        end
        if (lost_points) dropped_nodes++;
        oct_count   = '{default: 0};
        n_held      = 0;
        lost_points = 1'b0;
    endtask

    function automatic int pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 9);
        if (r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Point driver
    always @(posedge i_clk) begin
        t_point nxt;
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
            send_gap    <= 0;
        end else if (!pt_if.valid || pt_if.ready) begin
            if (send_gap != 0) begin
                pt_if.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end else if (points_to_send.size() != 0) begin
                nxt = points_to_send.pop_front();
                pt_if.valid  <= 1'b1;
                pt_if.x      <= nxt.x;
                pt_if.y      <= nxt.y;
                pt_if.z      <= nxt.z;
                pt_if.weight <= nxt.w;
                pt_if.last   <= nxt.last;
                send_gap     <= pick_gap();
            end else begin
                pt_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: result check, register and point tracking, back-pressure, watchdog
    always @(posedge i_clk) begin
        t_result want;
        t_point  got_pt;
        logic    moved;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
            idle_cycles  <= 0;
        end else begin
            moved = 1'b0;
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                results_seen++;
                if (node_results.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing outstanding",
                                     results_seen));
                end else begin
                    want = node_results.pop_front();
                    check_field("kind",        res_if.kind,        want.kind);
                    check_field("octant",      res_if.octant,      want.octant);
                    check_field("slot",        res_if.slot,        want.slot);
                    check_field("px",          res_if.px,          want.px);
                    check_field("py",          res_if.py,          want.py);
                    check_field("pz",          res_if.pz,          want.pz);
                    check_field("pweight",     res_if.pweight,     want.pw);
                    check_field("child_count", res_if.child_count, want.count);
                    check_field("overflow",    res_if.overflow,    want.ovf);
                    check_field("final_res",   res_if.final_res,   want.fin);
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                apply_reg(cfg_if.index, cfg_if.data);
            end
            if (pt_if.valid && pt_if.ready) begin
                moved = 1'b1;
                got_pt.x    = pt_if.x;
                got_pt.y    = pt_if.y;
                got_pt.z    = pt_if.z;
                got_pt.w    = pt_if.weight;
                got_pt.last = pt_if.last;
                points_taken++;
                absorb_point(got_pt);
            end

            // result back-pressure
            if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                stall_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(0, 2);
            end else begin
                res_if.ready <= 1'b1;
            end

            // watchdog on cycles without any transaction
            if (moved) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic queue_point(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] z, input logic signed [31:0] w,
                               input logic last);
        t_point p;
        p.x    = x;
        p.y    = y;
        p.z    = z;
        p.w    = w;
        p.last = last;
        points_to_send.push_back(p);
        stim_count++;
    endtask

    task automatic write_reg(input logic [octpart_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait until every point is taken and every result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (points_to_send.size() != 0 || pt_if.valid || node_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] near(input logic signed [31:0] c);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return c + 32'($urandom_range(0, 2 * SPAN)) - 32'(SPAN);
        if (r == 6) return c;
        if (r == 7) return $urandom();
        if (r == 8) return 32'sh7FFF_FFFF;
        return 32'sh8000_0000;
    endfunction

    function automatic logic signed [31:0] rand_weight();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r < 6) return $urandom();
        if (r == 6) return '0;
        return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    function automatic logic [31:0] rand_centre();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r < 4) return 32'($urandom_range(0, 2 ** 22)) - 32'(2 ** 21);
        if (r < 6) return $urandom();
        if (r == 6) return 32'h7FFF_FFFF;
        return 32'h8000_0000;
    endfunction

    function automatic logic [31:0] rand_radius();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r < 5) return $urandom_range(1, 2 ** 20);
        if (r == 5) return $urandom();
        if (r == 6) return 32'h7FFF_FFFF;
        return 32'd1;
    endfunction

    task automatic random_config();
        logic [5:0] leaf;
        leaf = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(1, 10));
        write_reg(octpart_pkg::CFG_CENTER_X, rand_centre());
        write_reg(octpart_pkg::CFG_CENTER_Y, rand_centre());
        write_reg(octpart_pkg::CFG_CENTER_Z, rand_centre());
        write_reg(octpart_pkg::CFG_RADIUS, rand_radius());
        write_reg(octpart_pkg::CFG_LEAF_LIMIT, ($urandom() & 32'hFFFF_FFC0) | 32'(leaf));
        write_reg(octpart_pkg::CFG_BASE_INDEX,
                  ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 65535));
    endtask

    task automatic queue_node(input int n);
        @(negedge i_clk);
        for (int i = 0; i < n; i++)
            queue_point(near(ctr_x), near(ctr_y), near(ctr_z), rand_weight(), i == n - 1);
    endtask

    // Stimulus
    initial begin
        logic [2:0] oc;
        int         n;
        int         pick;

        pt_if.valid  = 1'b0;
        pt_if.x      = '0;
        pt_if.y      = '0;
        pt_if.z      = '0;
        pt_if.weight = '0;
        pt_if.last   = 1'b0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = octpart_pkg::CFG_CENTER_X;
        cfg_if.data  = '0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: a one-point leaf, then a split node fed octants in reverse
        @(negedge i_clk);
        queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 1'b1);
        for (int k = 0; k < 8; k++) begin
            oc = 3'(7 - k);
            queue_point(oc[0] ? 32'sd3 : -32'sd3, oc[1] ? 32'sd70000 : -32'sd70000,
                        oc[2] ? 32'sd1 : -32'sd1, 32'(k * 1000), 1'b0);
        end
        queue_point(32'sd0, 32'sd0, 32'sd0, 32'sh8000_0000, 1'b1);

        // Centres near the rails, widest radius, every node split, top base index
        wait_idle();
        write_reg(octpart_pkg::CFG_CENTER_X, 32'h7FFF_0000);
        write_reg(octpart_pkg::CFG_CENTER_Y, 32'h8000_0005);
        write_reg(octpart_pkg::CFG_CENTER_Z, 32'h0000_0000);
        write_reg(octpart_pkg::CFG_RADIUS, 32'hFFFF_FFFF);
        write_reg(octpart_pkg::CFG_LEAF_LIMIT, 32'hFFFF_FFC0);
        write_reg(octpart_pkg::CFG_BASE_INDEX, 32'h0000_FFFF);
        @(negedge i_clk);
        queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, 32'sh7FFF_FFFF, 1'b1);
        queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5, 1'b0);
        queue_point(32'sh7FFF_0000, 32'sh8000_0005, 32'sd0, -32'sd5, 1'b0);
        queue_point(32'sh8000_0000, 32'sh8000_0006, 32'sh7FFF_FFFF, 32'sd9, 1'b1);

        // Opposite rails, zero half-step, leaf limit at its top, unmapped indexes
        wait_idle();
        write_reg(octpart_pkg::CFG_CENTER_X, 32'h8000_0000);
        write_reg(octpart_pkg::CFG_CENTER_Y, 32'h7FFF_FFFF);
        write_reg(octpart_pkg::CFG_CENTER_Z, 32'hFFFF_FFFF);
        write_reg(octpart_pkg::CFG_RADIUS, 32'd1);
        write_reg(octpart_pkg::CFG_LEAF_LIMIT, 32'd63);
        write_reg(octpart_pkg::CFG_BASE_INDEX, 32'd12345);
        write_reg(CFG_SPARE_6, 32'hDEAD_BEEF);
        write_reg(CFG_SPARE_7, 32'h1234_5678);
        @(negedge i_clk);
        queue_point(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0, 1'b0);
        queue_point(32'sh8000_0001, 32'sd0, 32'sd0, 32'sd7, 1'b0);
        queue_point(32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd7, 1'b1);

        // Zero radius, leaf limit of one: two points split, one point a leaf
        wait_idle();
        write_reg(octpart_pkg::CFG_RADIUS, 32'h8000_0000);
        write_reg(octpart_pkg::CFG_LEAF_LIMIT, 32'd1);
        write_reg(octpart_pkg::CFG_BASE_INDEX, 32'd0);
        @(negedge i_clk);
        queue_point(32'sd5, -32'sd5, 32'sd5, 32'sd1, 1'b0);
        queue_point(-32'sd5, 32'sd5, -32'sd5, 32'sd2, 1'b1);
        queue_point(32'sd0, 32'sd0, 32'sd0, 32'sd3, 1'b1);

        // Capacity: a leaf whose last point is dropped, then a split node with drops
        wait_idle();
        random_config();
        write_reg(octpart_pkg::CFG_LEAF_LIMIT, 32'd63);
        queue_node(MAX_PTS + 1);
        wait_idle();
        write_reg(octpart_pkg::CFG_LEAF_LIMIT, 32'd4);
        queue_node(MAX_PTS + 4);

        // Random nodes, mostly small, with drains and register changes between some
        while (stim_count < TARGET_PTS) begin
            @(negedge i_clk);
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                wait_idle();
                random_config();
            end else if (pick == 3) begin
                wait_idle();
            end
            @(negedge i_clk);
            steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = $urandom_range(MAX_PTS + 1, MAX_PTS + 8);
            else if (pick < 4)
                n = $urandom_range(13, MAX_PTS);
            else
                n = $urandom_range(1, 12);
            queue_node(n);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (node_results.size() != 0)
            report($sformatf("%0d results never arrived", node_results.size()));

        $display("Covered %0d nodes: %0d leaf, %0d split, %0d with dropped points",
                 leaf_nodes + split_nodes, leaf_nodes, split_nodes, dropped_nodes);
        $display("%0d points taken, %0d results checked, %0d register writes",
                 points_taken, results_seen, reg_writes);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
